FILE: rtl/pdr_pkg.sv
package pdr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_LEN    = 24;
    localparam int IDX_W        = $clog2(ANGLE_LEN);

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [30:0] INV_TWO_PI   = 31'sd683565276;

    localparam int DATA_W = 144;
    localparam int CFG_W  = 16;

    typedef enum logic [1:0] {
        REQ_CMD  = 2'd0,
        REQ_TICK = 2'd1,
        REQ_POSE = 2'd2
    } t_req;

    localparam logic CFG_STEP    = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        DP_NOP    = 3'd0,
        DP_PHASE  = 3'd1,
        DP_PREP   = 3'd2,
        DP_CORDIC = 3'd3,
        DP_MUL    = 3'd4,
        DP_INTEG  = 3'd5,
        DP_LOAD   = 3'd6
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    function automatic logic signed [33:0] angle_at(input logic [IDX_W-1:0] i);
        logic signed [33:0] a;
        case (i)
            5'd0:    a = 34'sd536870912;
            5'd1:    a = 34'sd316933406;
            5'd2:    a = 34'sd167458907;
            5'd3:    a = 34'sd85004756;
            5'd4:    a = 34'sd42667331;
            5'd5:    a = 34'sd21354465;
            5'd6:    a = 34'sd10679838;
            5'd7:    a = 34'sd5340245;
            5'd8:    a = 34'sd2670163;
            5'd9:    a = 34'sd1335087;
            5'd10:   a = 34'sd667544;
            5'd11:   a = 34'sd333772;
            5'd12:   a = 34'sd166886;
            5'd13:   a = 34'sd83443;
            5'd14:   a = 34'sd41722;
            5'd15:   a = 34'sd20861;
            5'd16:   a = 34'sd10430;
            5'd17:   a = 34'sd5215;
            5'd18:   a = 34'sd2608;
            5'd19:   a = 34'sd1304;
            5'd20:   a = 34'sd652;
            5'd21:   a = 34'sd326;
            5'd22:   a = 34'sd163;
            5'd23:   a = 34'sd81;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/pdr_ctrl.sv
module pdr_ctrl
    import pdr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    input  logic [1:0] i_req,
    output logic       o_s_ready,
    input  logic       i_m_ready,
    output logic       o_m_valid,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PHASE  = 7'b0000010,
        S_PREP   = 7'b0000100,
        S_CORDIC = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_INTEG  = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CORDIC_STEPS - 1);
    localparam logic [IDX_W-1:0] LAST_MUL  = IDX_W'(4);
    localparam logic [IDX_W-1:0] LAST_INT  = IDX_W'(3);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_valid, n_valid;
    logic             w_accept, w_load;

    assign o_s_ready = (r_state == S_IDLE);
    assign w_accept  = i_s_valid && o_s_ready;
    assign w_load    = (r_state == S_DONE) && (!r_valid || i_m_ready);
    assign o_m_valid = r_valid;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_valid    = r_valid && !i_m_ready;
        o_cmd.op   = DP_NOP;
        o_cmd.idx  = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_req == REQ_TICK)) begin
                    n_state = S_PHASE;
                end
            end
            S_PHASE: begin
                o_cmd.op = DP_PHASE;
                n_state  = S_PREP;
            end
            S_PREP: begin
                o_cmd.op = DP_PREP;
                n_cnt    = '0;
                n_state  = S_CORDIC;
            end
            S_CORDIC: begin
                o_cmd.op = DP_CORDIC;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op = DP_MUL;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == LAST_MUL) begin
                    n_cnt   = '0;
                    n_state = S_INTEG;
                end
            end
            S_INTEG: begin
                o_cmd.op = DP_INTEG;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == LAST_INT) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    o_cmd.op = DP_LOAD;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

endmodule

FILE: rtl/pdr_datapath.sv
module pdr_datapath
    import pdr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_accept,
    input  logic [1:0]        i_req,
    input  logic [DATA_W-1:0] i_tdata,
    input  t_dp_cmd           i_cmd,
    output logic [DATA_W-1:0] o_tdata
);

    logic [15:0]        r_step;
    logic [7:0]         r_timeout;
    logic [7:0]         r_silence;
    logic signed [31:0] r_pose [3];
    logic signed [31:0] r_last [3];
    logic signed [15:0] r_vel [3];
    logic signed [31:0] r_rx, r_ry;
    logic [31:0]        r_phase;
    logic signed [33:0] r_cx, r_cy, r_z;
    logic               r_flip;
    logic signed [51:0] r_prod, r_acc;
    logic [DATA_W-1:0]  r_out;

    logic signed [61:0] w_ph_prod;
    logic signed [33:0] w_z0, w_c, w_s, w_dx, w_dy, w_ang;
    logic signed [33:0] w_ma;
    logic signed [17:0] w_mb;
    logic signed [31:0] w_rh, w_rate;
    logic signed [52:0] w_sum, w_shift, w_inc, w_pos;
    logic [1:0]         w_ax;

    assign w_ph_prod = r_pose[2] * INV_TWO_PI;
    assign w_z0      = 34'(signed'(r_phase));
    assign w_c       = r_flip ? -r_cx : r_cx;
    assign w_s       = r_flip ? -r_cy : r_cy;
    assign w_dx      = r_cy >>> i_cmd.idx;
    assign w_dy      = r_cx >>> i_cmd.idx;
    assign w_ang     = angle_at(i_cmd.idx);
    assign w_rh      = {{4{r_vel[2][15]}}, r_vel[2], 12'b0};
    assign w_ax      = 2'(i_cmd.idx - 1'b1);

    always_comb begin
        w_rate = r_rx;
        case (i_cmd.idx[1:0])
            2'd1:    w_rate = r_ry;
            2'd2:    w_rate = w_rh;
            default: w_rate = r_rx;
        endcase
        w_ma = w_c;
        w_mb = 18'(r_vel[0]);
        if (i_cmd.op == DP_INTEG) begin
            w_ma = 34'(w_rate) + 34'(r_last[i_cmd.idx[1:0] == 2'd3 ? 2'd0 : i_cmd.idx[1:0]]);
            w_mb = {2'b0, r_step};
        end else begin
            case (i_cmd.idx[1:0])
                2'd1:    begin w_ma = w_s; w_mb = 18'(r_vel[1]); end
                2'd2:    begin w_ma = w_s; w_mb = 18'(r_vel[0]); end
                2'd3:    begin w_ma = w_c; w_mb = 18'(r_vel[1]); end
                default: begin w_ma = w_c; w_mb = 18'(r_vel[0]); end
            endcase
        end
        if (i_cmd.idx == IDX_W'(2)) begin
            w_sum = 53'(r_acc) - 53'(r_prod) + 53'sd2097152;
        end else begin
            w_sum = 53'(r_acc) + 53'(r_prod) + 53'sd2097152;
        end
        w_shift = w_sum >>> 22;
        w_inc   = (53'(r_prod) + 53'sd65536) >>> 17;
        w_pos   = 53'(r_pose[w_ax]) + w_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= 16'd655;
            r_timeout <= 8'd20;
            r_silence <= '0;
            for (int k = 0; k < 3; k++) begin
                r_pose[k] <= '0;
                r_last[k] <= '0;
                r_vel[k]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_STEP) begin
                    r_step <= i_cfg_data;
                end else begin
                    r_timeout <= i_cfg_data[7:0];
                end
            end
            if (i_accept) begin
                case (i_req)
                    REQ_CMD: begin
                        r_vel[0]  <= i_tdata[15:0];
                        r_vel[1]  <= i_tdata[31:16];
                        r_vel[2]  <= i_tdata[47:32];
                        r_silence <= '0;
                    end
                    REQ_TICK: begin
                        if (r_silence >= r_timeout) begin
                            for (int k = 0; k < 3; k++) begin
                                r_vel[k] <= '0;
                            end
                        end
                        if (r_silence != 8'hFF) begin
                            r_silence <= r_silence + 1'b1;
                        end
                    end
                    REQ_POSE: begin
                        r_pose[0] <= i_tdata[79:48];
                        r_pose[1] <= i_tdata[111:80];
                        r_pose[2] <= i_tdata[143:112];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.op == DP_INTEG && i_cmd.idx != '0) begin
                if (w_pos > 53'sd2147483647) begin
                    r_pose[w_ax] <= 32'sh7FFFFFFF;
                end else if (w_pos < -53'sd2147483648) begin
                    r_pose[w_ax] <= 32'sh80000000;
                end else begin
                    r_pose[w_ax] <= w_pos[31:0];
                end
                if (i_cmd.idx == IDX_W'(3)) begin
                    r_last[0] <= r_rx;
                    r_last[1] <= r_ry;
                    r_last[2] <= w_rh;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (i_cmd.op)
            DP_PHASE: begin
                r_phase <= w_ph_prod[55:24];
            end
            DP_PREP: begin
                r_cx   <= CORDIC_START;
                r_cy   <= '0;
                r_flip <= 1'b0;
                r_z    <= w_z0;
                if (w_z0 > 34'sd1073741824) begin
                    r_z    <= w_z0 - 34'sd2147483648;
                    r_flip <= 1'b1;
                end else if (w_z0 < -34'sd1073741824) begin
                    r_z    <= w_z0 + 34'sd2147483648;
                    r_flip <= 1'b1;
                end
            end
            DP_CORDIC: begin
                if (r_z >= 0) begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_z  <= r_z - w_ang;
                end else begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_z  <= r_z + w_ang;
                end
            end
            DP_MUL: begin
                case (i_cmd.idx)
                    IDX_W'(1): r_acc <= r_prod;
                    IDX_W'(2): r_rx  <= w_shift[31:0];
                    IDX_W'(3): r_acc <= r_prod;
                    IDX_W'(4): r_ry  <= w_shift[31:0];
                    default: begin
                    end
                endcase
            end
            DP_LOAD: begin
                r_out <= {r_vel[2], r_vel[1], r_vel[0], r_pose[2], r_pose[1], r_pose[0]};
            end
            default: begin
            end
        endcase
    end

    assign o_tdata = r_out;

endmodule

FILE: rtl/planar_dead_reckoning_integrator.sv
// Planar dead-reckoning integrator.
// The input stream carries one request per transaction: tuser selects a
// velocity command, a tick or a pose reset, and tdata holds surge, sway and
// yaw rate (Q8.8, Q8.8, Q4.12) followed by x, y and heading (Q16.16, Q16.16,
// Q8.24). A command or a pose reset is registered when accepted and gives
// no output. A tick keeps the block busy through a phase multiply, a setup
// step, 16 CORDIC iterations, the world rates on the shared multiplier and
// the trapezoid updates, run in turn on the one multiplier and the one
// CORDIC stage. The result, pose and velocity in effect, then moves to the
// output register and the block is ready again; it takes no new tick before
// that. While a result waits the block still takes commands and pose
// resets; a following tick is held back at its end until the output
// register is free. The configuration port writes the step size (index 0)
// or the timeout count (index 1). Reset returns the pose, velocity and
// rates to zero and the registers to 655 and 20.
module planar_dead_reckoning_integrator
    import pdr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: surge, sway, yaw_rate, reset_x, reset_y, reset_heading
    input  logic [DATA_W-1:0] s_axis_tdata,
    // tuser: req_type
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // tdata: pos_x, pos_y, heading, out_surge, out_sway, out_yaw_rate
    output logic [DATA_W-1:0] m_axis_tdata
);

    t_dp_cmd w_cmd;

    pdr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_req     (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (w_cmd)
    );

    pdr_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (s_axis_tvalid && s_axis_tready),
        .i_req      (s_axis_tuser),
        .i_tdata    (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_tdata    (m_axis_tdata)
    );

endmodule

FILE: rtl/pdr_checker.sv
module pdr_checker
    import pdr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [1:0]        s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_TICK |=> !s_axis_tready)
        else $error("ready right after a tick");

    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_TICK && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result shown without computation time");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind planar_dead_reckoning_integrator pdr_checker u_pdr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
